// ===== hw/rtl/rtp_h264_fragment_depacketizer_unit_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef RTP_H264_FRAGMENT_DEPACKETIZER_UNIT_MACROS_SVH
`define RTP_H264_FRAGMENT_DEPACKETIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfd check failed");

// Next-cycle implication, disabled in reset.
`define RFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfd check failed");

`endif

// ===== hw/rtl/rfd_pkg.sv =====
`timescale 1ns / 1ps
package rfd_pkg;

    // Widths fixed by the datagram format
    localparam int LEN_W = 5;
    localparam int POS_W = 4;

    // Byte positions within a datagram
    localparam logic [POS_W-1:0] POS_SEQ_HI = 4'd2;
    localparam logic [POS_W-1:0] POS_SEQ_LO = 4'd3;
    localparam logic [POS_W-1:0] POS_IND    = 4'd12;
    localparam logic [POS_W-1:0] POS_FU     = 4'd13;
    localparam logic [POS_W-1:0] POS_PAY    = 4'd14;

    // NAL unit types
    localparam logic [4:0] TYPE_SPS = 5'd7;
    localparam logic [4:0] TYPE_PPS = 5'd8;
    localparam logic [4:0] TYPE_FUA = 5'd28;

    // FU header bits and indicator mask
    localparam int         FU_START_BIT = 7;
    localparam int         FU_END_BIT   = 6;
    localparam logic [7:0] NRI_MASK     = 8'h60;
    localparam logic [1:0] SC_LAST_IDX  = 2'd3;

    // Output byte sources
    localparam logic [2:0] SRC_IN  = 3'd0;
    localparam logic [2:0] SRC_SC  = 3'd1;
    localparam logic [2:0] SRC_SPS = 3'd2;
    localparam logic [2:0] SRC_PPS = 3'd3;
    localparam logic [2:0] SRC_NAL = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       datagram_last;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        frame_end;
        logic        run_last;
        logic [15:0] lost_total;
    } t_out;

    // Controller -> datapath
    typedef struct packed {
        logic             take;
        logic             emit;
        logic [2:0]       src;
        logic [LEN_W-1:0] idx;
        logic             run_last;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic             busy;
        logic             pay_run;
        logic             hdr_start;
        logic [LEN_W-1:0] sps_len;
        logic [LEN_W-1:0] pps_len;
    } t_stat;

endpackage

// ===== hw/rtl/rfd_datapath.sv =====
`timescale 1ns / 1ps
module rfd_datapath #(
    parameter int SEQ_PARAM_MAX = 24,
    parameter int PIC_PARAM_MAX = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rfd_pkg::t_in  i_in_data,
    input  rfd_pkg::t_cmd i_cmd,
    output rfd_pkg::t_stat o_stat,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rfd_pkg::t_out o_out_data
);
    import rfd_pkg::*;

    localparam int SPS_AW = $clog2(SEQ_PARAM_MAX);
    localparam int PPS_AW = $clog2(PIC_PARAM_MAX);

    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_seq_hi;
    logic [15:0]      r_prev;
    logic             r_seen;
    logic [7:0]       r_ind;
    logic             r_end;
    logic [LEN_W-1:0] r_sps_len;
    logic [LEN_W-1:0] r_pps_len;
    logic [15:0]      r_lost;
    logic [7:0]       r_sps [SEQ_PARAM_MAX];
    logic [7:0]       r_pps [PIC_PARAM_MAX];
    logic             r_hold_last;
    logic [7:0]       r_nal;
    logic             r_out_valid;
    t_out             r_out;

    logic [7:0]  b;
    logic        last;
    logic [4:0]  cur_type;
    logic [15:0] seq_now;
    logic [15:0] seq_diff;
    logic [16:0] lost_sum;

    assign b        = i_in_data.data_byte;
    assign last     = i_in_data.datagram_last;
    assign cur_type = r_ind[4:0];
    assign seq_now  = {r_seq_hi, b};
    assign seq_diff = seq_now - r_prev;
    assign lost_sum = {1'b0, r_lost} + {1'b0, seq_diff} - 17'd1;

    // Status for the controller
    always_comb begin
        o_stat.busy      = r_out_valid && !i_out_ready;
        o_stat.pay_run   = (r_pos == POS_PAY) && (cur_type == TYPE_FUA);
        o_stat.hdr_start = (r_pos == POS_FU) && (cur_type == TYPE_FUA) && b[FU_START_BIT];
        o_stat.sps_len   = r_sps_len;
        o_stat.pps_len   = r_pps_len;
    end

    // Header parsing, sequence tracking and lengths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_seq_hi  <= '0;
            r_prev    <= '0;
            r_seen    <= 1'b0;
            r_ind     <= '0;
            r_end     <= 1'b0;
            r_sps_len <= '0;
            r_pps_len <= '0;
            r_lost    <= '0;
        end else if (i_cmd.take) begin
            if (r_pos == POS_SEQ_HI) begin
                r_seq_hi <= b;
            end else if (r_pos == POS_SEQ_LO) begin
                if (r_seen && (seq_diff > 16'd1)) begin
                    r_lost <= lost_sum[16] ? 16'hFFFF : lost_sum[15:0];
                end
                r_prev <= seq_now;
                r_seen <= 1'b1;
            end else if (r_pos == POS_IND) begin
                r_ind <= b;
            end else if (r_pos == POS_FU) begin
                r_end <= (cur_type == TYPE_FUA) && b[FU_END_BIT];
                if (cur_type == TYPE_SPS) begin
                    r_sps_len <= LEN_W'(2);
                end else if (cur_type == TYPE_PPS) begin
                    r_pps_len <= LEN_W'(2);
                end
            end else if (r_pos == POS_PAY) begin
                if (cur_type == TYPE_SPS && r_sps_len < LEN_W'(SEQ_PARAM_MAX)) begin
                    r_sps_len <= r_sps_len + LEN_W'(1);
                end else if (cur_type == TYPE_PPS && r_pps_len < LEN_W'(PIC_PARAM_MAX)) begin
                    r_pps_len <= r_pps_len + LEN_W'(1);
                end
            end

            if (last) begin
                r_pos <= '0;
            end else if (r_pos < POS_PAY) begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    // Parameter set stores and header-run holding registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_hold_last <= last;
            r_nal       <= (r_ind & NRI_MASK) | {3'b000, b[4:0]};
            if (r_pos == POS_FU) begin
                if (cur_type == TYPE_SPS) begin
                    r_sps[0] <= r_ind;
                    r_sps[1] <= b;
                end else if (cur_type == TYPE_PPS) begin
                    r_pps[0] <= r_ind;
                    r_pps[1] <= b;
                end
            end else if (r_pos == POS_PAY) begin
                if (cur_type == TYPE_SPS && r_sps_len < LEN_W'(SEQ_PARAM_MAX)) begin
                    r_sps[r_sps_len[SPS_AW-1:0]] <= b;
                end else if (cur_type == TYPE_PPS && r_pps_len < LEN_W'(PIC_PARAM_MAX)) begin
                    r_pps[r_pps_len[PPS_AW-1:0]] <= b;
                end
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload; store reads land here
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.run_last   <= i_cmd.run_last;
            r_out.lost_total <= r_lost;
            r_out.frame_end  <= 1'b0;
            case (i_cmd.src)
                SRC_IN: begin
                    r_out.out_byte  <= b;
                    r_out.frame_end <= last && r_end;
                end
                SRC_SC: begin
                    r_out.out_byte <= {7'd0, i_cmd.idx[1:0] == SC_LAST_IDX};
                end
                SRC_SPS: begin
                    r_out.out_byte <= r_sps[i_cmd.idx[SPS_AW-1:0]];
                end
                SRC_PPS: begin
                    r_out.out_byte <= r_pps[i_cmd.idx[PPS_AW-1:0]];
                end
                SRC_NAL: begin
                    r_out.out_byte  <= r_nal;
                    r_out.frame_end <= r_hold_last && r_end;
                end
                default: begin
                    r_out.out_byte <= '0;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/rfd_ctrl.sv =====
`timescale 1ns / 1ps
module rfd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rfd_pkg::t_stat i_stat,
    output rfd_pkg::t_cmd  o_cmd
);
    import rfd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SC1  = 3'd1;
    localparam logic [2:0] S_SPS  = 3'd2;
    localparam logic [2:0] S_SC2  = 3'd3;
    localparam logic [2:0] S_PPS  = 3'd4;
    localparam logic [2:0] S_SC3  = 3'd5;
    localparam logic [2:0] S_NAL  = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic             take;
    logic             sc_done;

    assign o_in_ready = (r_state == S_IDLE) && !i_stat.busy;
    assign take       = i_in_valid && o_in_ready;
    assign sc_done    = r_idx[1:0] == SC_LAST_IDX;

    // Header-run sequencer: start code, SPS, start code, PPS, start code, NAL header
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_cmd.take   = take;
        o_cmd.emit   = 1'b0;
        o_cmd.src    = SRC_IN;
        o_cmd.idx    = r_idx;
        o_cmd.run_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (take && i_stat.pay_run) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.run_last = 1'b1;
                end
                if (take && i_stat.hdr_start) begin
                    n_state = S_SC1;
                    n_idx   = '0;
                end
            end
            S_SC1, S_SC2, S_SC3: begin
                o_cmd.src = SRC_SC;
                if (!i_stat.busy) begin
                    o_cmd.emit = 1'b1;
                    n_idx      = r_idx + LEN_W'(1);
                    if (sc_done) begin
                        n_idx = '0;
                        if (r_state == S_SC1) begin
                            n_state = (i_stat.sps_len != '0) ? S_SPS : S_SC2;
                        end else if (r_state == S_SC2) begin
                            n_state = (i_stat.pps_len != '0) ? S_PPS : S_SC3;
                        end else begin
                            n_state = S_NAL;
                        end
                    end
                end
            end
            S_SPS: begin
                o_cmd.src = SRC_SPS;
                if (!i_stat.busy) begin
                    o_cmd.emit = 1'b1;
                    n_idx      = r_idx + LEN_W'(1);
                    if ((r_idx + LEN_W'(1)) == i_stat.sps_len) begin
                        n_idx   = '0;
                        n_state = S_SC2;
                    end
                end
            end
            S_PPS: begin
                o_cmd.src = SRC_PPS;
                if (!i_stat.busy) begin
                    o_cmd.emit = 1'b1;
                    n_idx      = r_idx + LEN_W'(1);
                    if ((r_idx + LEN_W'(1)) == i_stat.pps_len) begin
                        n_idx   = '0;
                        n_state = S_SC3;
                    end
                end
            end
            S_NAL: begin
                o_cmd.src = SRC_NAL;
                if (!i_stat.busy) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.run_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

// ===== hw/rtl/rtp_h264_fragment_depacketizer_unit.sv =====
`timescale 1ns / 1ps
// channel | valid      | ready       | payload
// --------+------------+-------------+--------------------------------------
// input   | i_in_valid | o_in_ready  | i_in_data  (data_byte, datagram_last)
// output  | o_out_valid| i_out_ready | o_out_data (out_byte, frame_end,
//         |            |             |             run_last, lost_total)
//
// An FU-A payload byte appears in the output register the cycle after it is
// taken. A start fragment's FU header byte launches a header run of
// 13 + SPS length + PPS length beats, one per cycle unless the output is
// stalled; input is held off meanwhile.
// A stalled output register holds off both the input and the sequencer.
// Reset is synchronous, active low; the parameter set stores are not cleared.
module rtp_h264_fragment_depacketizer_unit #(
    parameter int SEQ_PARAM_MAX = 24,
    parameter int PIC_PARAM_MAX = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rfd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rfd_pkg::t_out o_out_data
);
    import rfd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rfd_datapath #(
        .SEQ_PARAM_MAX (SEQ_PARAM_MAX),
        .PIC_PARAM_MAX (PIC_PARAM_MAX)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hw/rtl/rfd_checker.sv =====
`timescale 1ns / 1ps
`include "rtp_h264_fragment_depacketizer_unit_macros.svh"
module rfd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input rfd_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input rfd_pkg::t_out o_out_data
);
    // A stalled result beat holds
    `RFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    // No new byte is taken while the output register is stalled
    `RFD_ASSERT_NOW(a_no_take_on_stall, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready)
    // Frame end only on the last beat of a run
    `RFD_ASSERT_NOW(a_fe_run_last, i_clk, i_rst_n, o_out_valid && o_out_data.frame_end, o_out_data.run_last)
    // Output register is empty right after reset
    `RFD_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid)
endmodule

bind rtp_h264_fragment_depacketizer_unit rfd_checker u_rfd_checker (.*);

// ===== tb/rtp_h264_fragment_depacketizer_unit_test.sv =====
`timescale 1ns / 1ps
module rtp_h264_fragment_depacketizer_unit_test;
    import rfd_pkg::*;

    localparam int SPS_MAX      = 24;
    localparam int PPS_MAX      = 24;
    localparam int RANDOM_BYTES = 16;
    localparam int DRAIN_CYCLES = 80;
    // worst case: 61 beats per byte, long receiver stalls, a few times over
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_CAP    = 100;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    rtp_h264_fragment_depacketizer_unit #(
        .SEQ_PARAM_MAX(SPS_MAX),
        .PIC_PARAM_MAX(PPS_MAX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // Mirror of the depacketizer state
    logic [3:0]  m_pos      = '0;
    logic [7:0]  m_seq_hi   = '0;
    logic [15:0] m_prev_seq = '0;
    logic        m_seq_seen = 1'b0;
    logic [7:0]  m_ind      = '0;
    logic        m_end      = 1'b0;
    logic [7:0]  m_sps [SPS_MAX];
    logic [4:0]  m_sps_len  = '0;
    logic [7:0]  m_pps [PPS_MAX];
    logic [4:0]  m_pps_len  = '0;
    logic [15:0] m_lost     = '0;

    // Expected Annex B stream beats, oldest first
    t_out stream_expect_q[$];

    int err_count   = 0;
    int beats_seen  = 0;
    int cycle_count = 0;

    // Sender state
    int          burst_left = 0;
    int          bytes_sent = 0;
    logic [15:0] tx_seq     = '0;
    logic        in_frame   = 1'b0;
    logic [7:0]  pkt[$];

    task report_mismatch(input string msg);
        if (err_count < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    task push_stream_byte(input logic [7:0] b, input logic fe, input logic rl);
        t_out r;
        r.out_byte   = b;
        r.frame_end  = fe;
        r.run_last   = rl;
        r.lost_total = m_lost;
        stream_expect_q.push_back(r);
    endtask

    task push_start_code();
        push_stream_byte(8'h00, 1'b0, 1'b0);
        push_stream_byte(8'h00, 1'b0, 1'b0);
        push_stream_byte(8'h00, 1'b0, 1'b0);
        push_stream_byte(8'h01, 1'b0, 1'b0);
    endtask

    // Advance the mirror by one accepted datagram byte
    task rebuild_stream_byte(input t_in item);
        logic [7:0]  b;
        logic        last;
        logic [3:0]  pos;
        logic [4:0]  ty;
        logic [15:0] seq;
        logic [15:0] d;
        logic [16:0] sum;
        int          i;
        b    = item.data_byte;
        last = item.datagram_last;
        pos  = m_pos;
        ty   = m_ind[4:0];

        if (pos == POS_SEQ_HI) begin
            m_seq_hi = b;
        end else if (pos == POS_SEQ_LO) begin
            seq = {m_seq_hi, b};
            // modular gap; 0 and 1 count nothing
            if (m_seq_seen) begin
                d = seq - m_prev_seq;
                if (d > 16'd1) begin
                    sum    = {1'b0, m_lost} + {1'b0, d} - 17'd1;
                    m_lost = sum[16] ? 16'hFFFF : sum[15:0];
                end
            end
            m_prev_seq = seq;
            m_seq_seen = 1'b1;
        end else if (pos == POS_IND) begin
            m_ind = b;
        end else if (pos == POS_FU) begin
            m_end = (ty == TYPE_FUA) && b[FU_END_BIT];
            if (ty == TYPE_SPS) begin
                m_sps[0]  = m_ind;
                m_sps[1]  = b;
                m_sps_len = 5'd2;
            end else if (ty == TYPE_PPS) begin
                m_pps[0]  = m_ind;
                m_pps[1]  = b;
                m_pps_len = 5'd2;
            end else if (ty == TYPE_FUA && b[FU_START_BIT]) begin
                // header run: SC, SPS, SC, PPS, SC, rebuilt NAL header
                push_start_code();
                for (i = 0; i < m_sps_len; i++)
                    push_stream_byte(m_sps[i], 1'b0, 1'b0);
                push_start_code();
                for (i = 0; i < m_pps_len; i++)
                    push_stream_byte(m_pps[i], 1'b0, 1'b0);
                push_start_code();
                push_stream_byte((m_ind & NRI_MASK) | {3'b000, b[4:0]},
                                 last && m_end, 1'b1);
            end
        end else if (pos >= POS_PAY) begin
            if (ty == TYPE_SPS) begin
                if (m_sps_len < SPS_MAX) begin
                    m_sps[m_sps_len] = b;
                    m_sps_len = m_sps_len + 5'd1;
                end
            end else if (ty == TYPE_PPS) begin
                if (m_pps_len < PPS_MAX) begin
                    m_pps[m_pps_len] = b;
                    m_pps_len = m_pps_len + 5'd1;
                end
            end else if (ty == TYPE_FUA) begin
                push_stream_byte(b, last && m_end, 1'b1);
            end
        end

        if (last)
            m_pos = '0;
        else if (pos < POS_PAY)
            m_pos = pos + 4'd1;
    endtask

    // Send one datagram byte; bursts of random length with random gaps
    task send_byte(input logic [7:0] b, input logic last);
        t_in item;
        int  gap;
        item.data_byte     = b;
        item.datagram_last = last;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        rebuild_stream_byte(item);
    endtask

    function logic [7:0] nal_ind(input logic [1:0] nri, input logic [4:0] ty);
        return {1'b0, nri, ty};
    endfunction

    function logic [7:0] fu_hdr(input logic s, input logic e, input logic [4:0] ty);
        return {s, e, 1'b0, ty};
    endfunction

    // 12-byte RTP header with tx_seq, then indicator, FU/second byte, payload
    task build_packet(input logic [7:0] ind, input logic [7:0] fu, input int pay_len);
        int i;
        pkt.delete();
        pkt.push_back(8'($urandom));
        pkt.push_back(8'($urandom));
        pkt.push_back(tx_seq[15:8]);
        pkt.push_back(tx_seq[7:0]);
        for (i = 0; i < 8; i++)
            pkt.push_back(8'($urandom));
        pkt.push_back(ind);
        pkt.push_back(fu);
        for (i = 0; i < pay_len; i++)
            pkt.push_back(8'($urandom));
    endtask

    // Send the first count bytes of the built packet
    task send_packet(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_byte(pkt[i], i == count - 1);
        if (count > POS_SEQ_LO)
            tx_seq = tx_seq + 16'd1;
    endtask

    // Datagrams that end before the FU header; first sequence number wraps
    task test_short_datagrams();
        tx_seq = 16'hFFFE;
        build_packet(nal_ind(2'd3, TYPE_FUA), fu_hdr(1'b1, 1'b0, 5'd5), 0);
        send_packet(1);
        send_packet(4);
        build_packet(nal_ind(2'd1, TYPE_FUA), fu_hdr(1'b1, 1'b0, 5'd5), 0);
        send_packet(13);
        // start+end with no payload, empty parameter sets
        build_packet(nal_ind(2'd2, TYPE_FUA), fu_hdr(1'b1, 1'b1, 5'd1), 0);
        send_packet(pkt.size());
    endtask

    // Parameter set capture, truncation, and the full header run
    task test_parameter_sets();
        // both sets run past the store size and are truncated
        build_packet(nal_ind(2'd3, TYPE_PPS), 8'hCE, 23);
        send_packet(pkt.size());
        build_packet(nal_ind(2'd3, TYPE_SPS), 8'h64, 23);
        send_packet(pkt.size());
        // longest header run, then one payload byte
        build_packet(nal_ind(2'd0, TYPE_FUA), fu_hdr(1'b1, 1'b0, 5'd31), 1);
        send_packet(pkt.size());
    endtask

    // Start / middle / end fragments and their corner cases
    task test_fragments();
        // end fragment closing the frame opened above
        build_packet(nal_ind(2'd0, TYPE_FUA), fu_hdr(1'b0, 1'b1, 5'd31), 1);
        send_packet(pkt.size());
        // end fragment with nothing after the FU header: no frame end
        build_packet(nal_ind(2'd1, TYPE_FUA), fu_hdr(1'b0, 1'b1, 5'd1), 0);
        send_packet(pkt.size());
        // start and end together, forbidden bit masked off, payload once
        build_packet(8'h80 | nal_ind(2'd3, TYPE_FUA), 8'hFF, 1);
        send_packet(pkt.size());
    endtask

    // Types other than SPS, PPS and FU-A produce nothing
    task test_other_types();
        logic [4:0] ty_list [2];
        int k;
        ty_list = '{5'd5, 5'd24};
        for (k = 0; k < 2; k++) begin
            build_packet(nal_ind(2'($urandom), ty_list[k]), 8'hC0, 0);
            send_packet(pkt.size());
        end
    endtask

    // Duplicate, in-order and forward-gap sequence numbers
    task test_sequence_gaps();
        build_packet(nal_ind(2'd0, TYPE_PPS), 8'h00, 0);
        send_packet(4);
        tx_seq = tx_seq - 16'd1;
        send_packet(4);
        tx_seq = tx_seq + 16'd3;
        send_packet(4);
    endtask

    // Mostly well-formed frames with random content, plus noise
    task random_datagram();
        int         kind;
        int         pay;
        logic       s;
        logic       e;
        logic [4:0] ty;
        kind = $urandom_range(0, 19);
        pay  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30)
                                           : $urandom_range(0, 6);
        // occasional duplicate or forward jump
        if ($urandom_range(0, 9) == 0)
            tx_seq = tx_seq + 16'($urandom_range(0, 4)) - 16'd1;
        if (kind < 12) begin
            s = !in_frame;
            e = in_frame ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 5) == 0);
            if (kind == 11) begin
                s = 1'($urandom);
                e = 1'($urandom);
            end
            in_frame = e ? 1'b0 : (s ? 1'b1 : in_frame);
            build_packet({1'($urandom), 2'($urandom), TYPE_FUA},
                         {s, e, 1'($urandom), 5'($urandom)}, pay);
            send_packet(pkt.size());
        end else if (kind < 16) begin
            ty = (kind < 14) ? TYPE_SPS : TYPE_PPS;
            build_packet({1'($urandom), 2'($urandom), ty}, 8'($urandom), pay);
            send_packet(pkt.size());
        end else begin
            do ty = 5'($urandom);
            while (ty == TYPE_SPS || ty == TYPE_PPS || ty == TYPE_FUA);
            if (kind == 19)
                ty = TYPE_FUA;
            build_packet({1'($urandom), 2'($urandom), ty}, 8'($urandom), pay);
            // broken datagrams are cut short
            send_packet(kind >= 18 ? $urandom_range(1, 14) : pkt.size());
        end
    endtask

    task test_random();
        int start_bytes;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
            random_datagram();
    endtask

    // Backward steps count as huge gaps and saturate the lost count
    task test_lost_saturation();
        build_packet(nal_ind(2'd0, TYPE_SPS), 8'h00, 0);
        send_packet(4);
        tx_seq = tx_seq - 16'd2;
        send_packet(4);
        tx_seq = tx_seq - 16'd3;
        build_packet(nal_ind(2'd2, TYPE_FUA), fu_hdr(1'b0, 1'b1, 5'd1), 1);
        send_packet(pkt.size());
    endtask

    // Receiver: compare each accepted beat, then pick the next ready
    int   rx_mode   = 0;
    int   rx_left   = 0;
    int   rx_hold   = 0;
    int   rx_phase  = 0;

    always @(posedge i_clk) begin : rx_side
        t_out want;
        logic rdy;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (stream_expect_q.size() == 0) begin
                report_mismatch($sformatf("beat %0d arrived with nothing expected",
                                          beats_seen));
            end else begin
                want = stream_expect_q.pop_front();
                if (o_out_data.out_byte !== want.out_byte)
                    report_mismatch($sformatf("beat %0d out_byte got %02h want %02h",
                        beats_seen, o_out_data.out_byte, want.out_byte));
                if (o_out_data.frame_end !== want.frame_end)
                    report_mismatch($sformatf("beat %0d frame_end got %b want %b",
                        beats_seen, o_out_data.frame_end, want.frame_end));
                if (o_out_data.run_last !== want.run_last)
                    report_mismatch($sformatf("beat %0d run_last got %b want %b",
                        beats_seen, o_out_data.run_last, want.run_last));
                if (o_out_data.lost_total !== want.lost_total)
                    report_mismatch($sformatf("beat %0d lost_total got %04h want %04h",
                        beats_seen, o_out_data.lost_total, want.lost_total));
            end
            beats_seen++;
        end

        // stall pattern: free-running, coin flip, every fourth, long holds
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 120);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            0: begin
                rdy = 1'b1;
            end
            1: begin
                rdy = 1'($urandom);
            end
            2: begin
                rdy = (rx_phase % 4) != 0;
            end
            default: begin
                if (rx_hold > 0) begin
                    rdy = 1'b0;
                    rx_hold--;
                end else begin
                    rdy = 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        rx_hold = $urandom_range(1, 8);
                end
            end
        endcase
        i_out_ready <= rdy;
    end

    // Hang guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_datagrams();
        test_parameter_sets();
        test_sequence_gaps();
        test_fragments();
        test_other_types();
        test_random();
        test_lost_saturation();

        i_in_valid <= 1'b0;
        while (stream_expect_q.size() != 0) @(posedge i_clk);
        // catch stray beats after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
